// File: rtl/core/lzss_wmf_pkg.sv
// ----------------------------------------------------------------------------
// LZSS window match finder package
// Item layouts, codes, controller command/status groups and sizes.
// ----------------------------------------------------------------------------
package lzss_wmf_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int LOOK_SIZE    = 16;
  localparam int MAX_MATCHES  = 32;

  localparam int WIN_AW  = 8;
  localparam int LOOK_AW = 4;
  localparam int LEN_W   = 5;
  localparam int MIN_W   = 4;

  localparam logic [MIN_W-1:0] MIN_MATCH_RST = 4'd2;

  localparam logic [1:0] FUNC_WIN_WR  = 2'd0;
  localparam logic [1:0] FUNC_LOOK_WR = 2'd1;
  localparam logic [1:0] FUNC_SEARCH  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         addr;
    logic [7:0]         data;
    logic [WIN_AW-1:0]  window_head;
    logic [LOOK_AW-1:0] look_head;
  } in_item_t;

  typedef struct packed {
    logic               match_valid;
    logic [WIN_AW-1:0]  match_offset;
    logic [LEN_W-1:0]   match_length;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic win_wr;
    logic look_wr;
    logic load;
    logic issue;
    logic step;
    logic eval;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic cmp_more;
    logic eval_ok;
    logic last_pos;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/lzss_wmf_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS window match finder controller
// Sequences writes and the per-position read/compare/evaluate search loop.
// ----------------------------------------------------------------------------
module lzss_wmf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_func,
  input  lzss_wmf_pkg::status_t sts,
  output lzss_wmf_pkg::cmd_t    cmd,
  output logic                  in_stall
);

  lzss_wmf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzss_wmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != lzss_wmf_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      lzss_wmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            lzss_wmf_pkg::FUNC_WIN_WR:  cmd.win_wr  = 1'b1;
            lzss_wmf_pkg::FUNC_LOOK_WR: cmd.look_wr = 1'b1;
            lzss_wmf_pkg::FUNC_SEARCH: begin
              cmd.load  = 1'b1;
              state_nxt = lzss_wmf_pkg::ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      lzss_wmf_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = lzss_wmf_pkg::ST_CMP;
      end
      lzss_wmf_pkg::ST_CMP: begin
        cmd.step = 1'b1;
        if (!sts.cmp_more) begin
          state_nxt = lzss_wmf_pkg::ST_EVAL;
        end
      end
      lzss_wmf_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.eval_ok) begin
          state_nxt = sts.last_pos ? lzss_wmf_pkg::ST_FLUSH : lzss_wmf_pkg::ST_ISSUE;
        end
      end
      lzss_wmf_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.out_free) begin
          state_nxt = lzss_wmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lzss_wmf_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/lzss_wmf_dp.sv
// ----------------------------------------------------------------------------
// LZSS window match finder datapath
// Window memory, lookahead bytes, scan counters, pending match and output.
// ----------------------------------------------------------------------------
module lzss_wmf_dp #(
  parameter int MAX_MATCHES = lzss_wmf_pkg::MAX_MATCHES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lzss_wmf_pkg::cmd_t                   cmd,
  output lzss_wmf_pkg::status_t                sts,
  input  lzss_wmf_pkg::in_item_t               in_data,
  input  logic                                 cfg_wr,
  input  logic [lzss_wmf_pkg::MIN_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lzss_wmf_pkg::out_item_t              out_data
);

  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam int AW    = lzss_wmf_pkg::WIN_AW;
  localparam int LW    = lzss_wmf_pkg::LEN_W;
  localparam int LAW   = lzss_wmf_pkg::LOOK_AW;

  logic [7:0] win_mem [lzss_wmf_pkg::WINDOW_DEPTH];
  logic [7:0] look_r  [lzss_wmf_pkg::LOOK_SIZE];

  logic [7:0]                     rd_data_r;
  logic [AW-1:0]                  rd_addr;
  logic                           rd_en;
  logic [AW-1:0]                  pos_r;
  logic [AW-1:0]                  pos_cnt_r;
  logic [LAW-1:0]                 newest_r;
  logic [LW-1:0]                  len_r;
  logic [lzss_wmf_pkg::MIN_W-1:0] min_match_r;
  logic [CNT_W-1:0]               count_r;
  logic                           dropped_r;
  logic                           pend_v_r;
  lzss_wmf_pkg::out_item_t        pend_r;
  logic                           out_valid_r;
  lzss_wmf_pkg::out_item_t        out_data_r;

  logic       eq;
  logic       is_match;
  logic       room;
  logic       out_free;
  logic       eval_ok;
  logic       take;
  logic       out_load;
  logic [7:0] look_byte;
  lzss_wmf_pkg::out_item_t new_match;
  lzss_wmf_pkg::out_item_t final_item;

  // Read address walks backward from the current position
  assign rd_en   = cmd.issue | cmd.step;
  assign rd_addr = cmd.issue ? pos_r : pos_r - AW'(len_r + LW'(1));

  always_ff @(posedge clk) begin
    if (cmd.win_wr) begin
      win_mem[in_data.addr[AW-1:0]] <= in_data.data;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look_wr && (in_data.addr < 8'(lzss_wmf_pkg::LOOK_SIZE))) begin
      look_r[in_data.addr[LAW-1:0]] <= in_data.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_match_r <= lzss_wmf_pkg::MIN_MATCH_RST;
    end else if (cfg_wr) begin
      min_match_r <= cfg_data;
    end
  end

  assign look_byte = look_r[newest_r - len_r[LAW-1:0]];
  assign eq        = (rd_data_r == look_byte);
  assign is_match  = (len_r > LW'(min_match_r));
  assign room      = (count_r < CNT_W'(MAX_MATCHES));
  assign out_free  = !out_valid_r || !out_stall;
  // A new match pushes the pending one out; wait if the output is busy
  assign eval_ok   = !(is_match && room && pend_v_r && !out_free);
  assign take      = cmd.eval && eval_ok && is_match && room;
  assign out_load  = (take && pend_v_r) || (cmd.flush && out_free);

  always_comb begin
    new_match              = '0;
    new_match.match_valid  = 1'b1;
    new_match.match_offset = pos_r - AW'(len_r - LW'(1));
    new_match.match_length = len_r;
  end

  always_comb begin
    final_item = '0;
    if (pend_v_r) begin
      final_item          = pend_r;
      final_item.overflow = dropped_r;
    end
    final_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r     <= in_data.window_head;
      newest_r  <= in_data.look_head - LAW'(1);
      pos_cnt_r <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end
    if (cmd.issue) begin
      len_r <= '0;
    end else if (cmd.step && eq) begin
      len_r <= len_r + LW'(1);
    end
    if (cmd.eval && eval_ok) begin
      pos_r     <= pos_r + AW'(1);
      pos_cnt_r <= pos_cnt_r + AW'(1);
      if (is_match && !room) begin
        dropped_r <= 1'b1;
      end
    end
    if (take) begin
      pend_r  <= new_match;
      count_r <= count_r + CNT_W'(1);
    end
    if (out_load) begin
      out_data_r <= cmd.flush ? final_item : pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_v_r <= 1'b0;
      end else if (take) begin
        pend_v_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.cmp_more = eq && (len_r != LW'(lzss_wmf_pkg::LOOK_SIZE - 1));
  assign sts.eval_ok  = eval_ok;
  assign sts.last_pos = (pos_cnt_r == AW'(lzss_wmf_pkg::WINDOW_DEPTH - 1));
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/lzss_window_match_finder_unit.sv
// ----------------------------------------------------------------------------
// LZSS window match finder
// Brute-force search of a 256-byte circular window against a 16-byte lookahead.
// ----------------------------------------------------------------------------
// Write items (window or lookahead byte) give no result.
// A search item walks all 256 window positions from window_head; at each one
// the single window memory read port is read once per compared byte, and a
// stall on the result side holds the search. Each run longer than min_match
// gives one result, the first 32 only; the final result has last set, and
// overflow if later matches were dropped. A search with no match gives one
// empty result. The input side stalls for the whole search; the result
// register lets the next item be accepted while the last result still waits.
module lzss_window_match_finder_unit #(
  parameter int MAX_MATCHES = lzss_wmf_pkg::MAX_MATCHES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lzss_wmf_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lzss_wmf_pkg::out_item_t          out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lzss_wmf_pkg::MIN_W-1:0]   cfg_data
);

  lzss_wmf_pkg::cmd_t    cmd;
  lzss_wmf_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  lzss_wmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lzss_wmf_dp #(
    .MAX_MATCHES (MAX_MATCHES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.func == lzss_wmf_pkg::FUNC_SEARCH) |=> in_stall)
    else $error("input not stalled after search item");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.step, cmd.eval, cmd.flush}))
    else $error("more than one search command at once");

  a_compare_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> $past(cmd.issue || cmd.step))
    else $error("compare without a preceding window read");
`endif

endmodule

// File: tb/sv/lzss_window_match_finder_unit_test.sv
// ----------------------------------------------------------------------------
// LZSS window match finder testbench
// Fills both byte stores once with low-entropy bytes, then runs directed and
// random write/search items against a cycle-free predictor of the brute-force
// match scan. Each result item is checked field by field, in order, under
// random idling on both sides, a long result-side hold-off and several
// min_match settings.
// ----------------------------------------------------------------------------
module lzss_window_match_finder_unit_test;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 10;
  localparam int unsigned LONG_HOLD = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lzss_wmf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lzss_wmf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lzss_wmf_pkg::MIN_W-1:0] cfg_data = '0;

  // predicted block state
  logic [7:0] win_mem [lzss_wmf_pkg::WINDOW_DEPTH];
  logic [7:0] look_mem [lzss_wmf_pkg::LOOK_SIZE];
  logic [lzss_wmf_pkg::MIN_W-1:0] min_len = lzss_wmf_pkg::MIN_MATCH_RST;
  lzss_wmf_pkg::out_item_t pending_matches[$];

  // stimulus side
  lzss_wmf_pkg::in_item_t pending_items[$];
  logic [7:0] gen_win [lzss_wmf_pkg::WINDOW_DEPTH];
  logic [7:0] sym_a, sym_b;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit in_fire = 1'b0;
  bit idle_on = 1'b1;

  lzss_window_match_finder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Applies one accepted item to the predicted stores; a search queues its results.
  task automatic apply_item(input lzss_wmf_pkg::in_item_t it);
    lzss_wmf_pkg::out_item_t hits[$];
    lzss_wmf_pkg::out_item_t hit;
    logic [3:0] newest;
    logic [7:0] pos;
    int unsigned len;
    bit dropped;
    dropped = 1'b0;
    case (it.func)
      lzss_wmf_pkg::FUNC_WIN_WR: win_mem[it.addr] = it.data;
      lzss_wmf_pkg::FUNC_LOOK_WR:
        if (it.addr < lzss_wmf_pkg::LOOK_SIZE)
          look_mem[it.addr[lzss_wmf_pkg::LOOK_AW-1:0]] = it.data;
      lzss_wmf_pkg::FUNC_SEARCH: begin
        newest = it.look_head - 4'd1;
        for (int p = 0; p < lzss_wmf_pkg::WINDOW_DEPTH; p++) begin
          pos = it.window_head + 8'(p);
          len = 0;
          // backward walk, both stores circular
          while (len < lzss_wmf_pkg::LOOK_SIZE &&
                 win_mem[8'(pos - 8'(len))] == look_mem[4'(newest - 4'(len))])
            len++;
          if (len > min_len) begin
            if (hits.size() < lzss_wmf_pkg::MAX_MATCHES) begin
              hit = '0;
              hit.match_valid = 1'b1;
              hit.match_offset = 8'(pos - 8'(len) + 8'd1);
              hit.match_length = 5'(len);
              hits.push_back(hit);
            end else begin
              dropped = 1'b1;
            end
          end
        end
        if (hits.size() == 0) begin
          hit = '0;
          hit.last = 1'b1;
          hits.push_back(hit);
        end else begin
          hits[hits.size()-1].overflow = dropped;
          hits[hits.size()-1].last = 1'b1;
        end
        foreach (hits[k]) pending_matches.push_back(hits[k]);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    lzss_wmf_pkg::out_item_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (!rst_n) min_len = lzss_wmf_pkg::MIN_MATCH_RST;
    else if (cfg_valid && cfg_ready) min_len = cfg_data;
    if (in_fire) begin
      apply_item(in_data);
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("result with nothing pending, offset", out_data.match_offset, 8'h00);
      end else begin
        want = pending_matches.pop_front();
        if (out_data.match_valid !== want.match_valid)
          report_mismatch("match_valid", out_data.match_valid, want.match_valid);
        if (out_data.match_offset !== want.match_offset)
          report_mismatch("match_offset", out_data.match_offset, want.match_offset);
        if (out_data.match_length !== want.match_length)
          report_mismatch("match_length", out_data.match_length, want.match_length);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  always @(negedge clk) begin : driver
    if (!in_valid || in_fire) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return sym_a;
    if (r < 17) return sym_b;
    return 8'($urandom);
  endfunction

  // a byte value that the queued window contents do not hold
  function automatic logic [7:0] absent_byte();
    bit seen [256];
    logic [7:0] v;
    foreach (seen[k]) seen[k] = 1'b0;
    for (int a = 0; a < lzss_wmf_pkg::WINDOW_DEPTH; a++) seen[gen_win[a]] = 1'b1;
    v = 8'h00;
    for (int k = 255; k >= 0; k--)
      if (!seen[k]) v = 8'(k);
    return v;
  endfunction

  task automatic queue_item(input logic [1:0] func, input logic [7:0] addr,
                            input logic [7:0] data, input logic [7:0] wh,
                            input logic [3:0] lh);
    lzss_wmf_pkg::in_item_t it;
    it.func = func;
    it.addr = addr;
    it.data = data;
    it.window_head = wh;
    it.look_head = lh;
    pending_items.push_back(it);
    n_queued++;
    if (func == lzss_wmf_pkg::FUNC_WIN_WR) gen_win[addr] = data;
  endtask

  // Copies a window string ending at 'at' into the lookahead so that a long run
  // exists, then searches.
  task automatic plant_match(input logic [7:0] at, input int unsigned n,
                             input logic [3:0] lh);
    logic [3:0] slot;
    for (int k = 0; k < n; k++) begin
      slot = lh - 4'd1 - 4'(k);
      queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, {4'h0, slot}, gen_win[8'(at - 8'(k))],
                 8'($urandom), 4'($urandom));
    end
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'($urandom), 8'($urandom), 8'($urandom), lh);
  endtask

  task automatic queue_random_item();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'($urandom), 8'($urandom), 8'($urandom),
                 4'($urandom));
    else if (pick < 55)
      queue_item(lzss_wmf_pkg::FUNC_WIN_WR, 8'($urandom), pick_byte(), 8'($urandom),
                 4'($urandom));
    else if (pick < 72)
      queue_item(lzss_wmf_pkg::FUNC_LOOK_WR,
                 8'($urandom_range(0, lzss_wmf_pkg::LOOK_SIZE - 1)), pick_byte(),
                 8'($urandom), 4'($urandom));
    else if (pick < 84) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, lzss_wmf_pkg::LOOK_SIZE)
                                      : lzss_wmf_pkg::LOOK_SIZE;
      plant_match(8'($urandom), n, 4'($urandom));
    end else if (pick < 92)
      queue_item(lzss_wmf_pkg::FUNC_LOOK_WR,
                 8'($urandom_range(lzss_wmf_pkg::LOOK_SIZE, 255)), 8'($urandom),
                 8'($urandom), 4'($urandom));
    else
      queue_item(FUNC_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic write_min_len(input logic [lzss_wmf_pkg::MIN_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds back until every item is taken and every result is in
  task automatic wait_idle();
    while (n_taken != n_queued || pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned start;
    logic [7:0] absent;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // low-entropy contents so that runs of useful length are common;
    // every entry written before any search reads it
    sym_a = 8'($urandom);
    sym_b = ~sym_a;
    for (int a = 0; a < lzss_wmf_pkg::WINDOW_DEPTH; a++)
      queue_item(lzss_wmf_pkg::FUNC_WIN_WR, 8'(a), pick_byte(), 8'($urandom), 4'($urandom));
    for (int a = 0; a < lzss_wmf_pkg::LOOK_SIZE; a++)
      queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'(a), pick_byte(), 8'($urandom),
                 4'($urandom));
    absent = absent_byte();

    // heads at both ends of their ranges
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'h00, 8'h00, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'hFF, 8'hFF, 8'hFF, 4'hF);
    // newest lookahead byte for head 0 found nowhere: empty result
    queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'd15, absent, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'h00, 8'h00, 8'h00, 4'h0);
    // out-of-range lookahead writes and unknown func are dropped
    queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'd16, absent, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'd255, absent, 8'hFF, 4'hF);
    queue_item(FUNC_NOP, 8'hFF, 8'hFF, 8'hFF, 4'hF);
    queue_item(FUNC_NOP, 8'h00, 8'h00, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'h00, 8'h00, 8'h00, 4'h1);
    // full-length run whose backward walk wraps the window end
    plant_match(8'd3, lzss_wmf_pkg::LOOK_SIZE, 4'h0);
    wait_idle();

    // only the full-length run passes the highest threshold
    write_min_len(4'd15);
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'h00, 8'h00, 8'h80, 4'h0);
    wait_idle();

    // common symbol as the two newest bytes: more matches than reported
    write_min_len(4'd1);
    queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'd15, sym_a, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_LOOK_WR, 8'd14, sym_a, 8'h00, 4'h0);
    queue_item(lzss_wmf_pkg::FUNC_SEARCH, 8'h00, 8'h00, 8'h40, 4'h0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: write_min_len(4'd1);
        2: write_min_len(lzss_wmf_pkg::MIN_MATCH_RST);
        default: write_min_len(4'($urandom_range(1, 15)));
      endcase
      if (ph == 0) begin
        @(posedge clk);
        hold_left = LONG_HOLD;
      end
      if (ph == 3) idle_on = 1'b0;
      start = n_queued;
      while (n_queued - start < PHASE_ITEMS) queue_random_item();
    end
    wait_idle();

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lzss_wmf_pkg.sv
rtl/core/lzss_wmf_ctrl.sv
rtl/core/lzss_wmf_dp.sv
rtl/core/lzss_window_match_finder_unit.sv
tb/sv/lzss_window_match_finder_unit_test.sv
